@@ rtl/sse_pkg.sv @@
package sse_pkg;

    localparam int KEY_W   = 16;
    localparam int OP_W    = 2;
    localparam int COUNT_W = 7;

    localparam logic [OP_W-1:0] OP_MEMBER = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

@@ rtl/sse_cell.sv @@
module sse_cell (
    input  logic                          i_clk,
    input  sse_pkg::t_cell_ctl            i_ctl,
    input  logic [sse_pkg::KEY_W-1:0]     i_key,
    input  logic                          i_in_use,
    input  logic [sse_pkg::KEY_W-1:0]     i_lower_value,
    input  logic [sse_pkg::KEY_W-1:0]     i_upper_value,
    input  logic                          i_lower_lt,
    output logic [sse_pkg::KEY_W-1:0]     o_value,
    output logic                          o_lt,
    output logic                          o_eq
);

    logic [sse_pkg::KEY_W-1:0] r_value;
    logic [sse_pkg::KEY_W-1:0] n_value;
    logic                      r_lt;
    logic                      r_eq;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins && !r_lt) begin
            n_value = i_lower_lt ? i_key : i_lower_value;
        end else if (i_ctl.del && !r_lt) begin
            n_value = i_upper_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctl.cmp) begin
            r_lt <= i_in_use && (r_value < i_key);
            r_eq <= i_in_use && (r_value == i_key);
        end
    end

    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

@@ rtl/sorted_set_engine_top.sv @@
// Channel   Valid        Ready        Payload
// request   i_in_valid   o_in_ready   i_operation, i_key_value
// result    o_out_valid  i_out_ready  o_success, o_store_full, o_entry_count
//
// Each word passes through capture, a compare in every cell, then the update.
// The update shifts every cell not below the key by one at once, so CAPACITY does not change the rate.
// Reset clears the count and the control state; the value cells are not cleared.
// A waiting result holds the update step until the result register is free.
module sorted_set_engine_top #(
    parameter int CAPACITY = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sse_pkg::OP_W-1:0]      i_operation,
    input  logic [sse_pkg::KEY_W-1:0]     i_key_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_success,
    output logic                          o_store_full,
    output logic [sse_pkg::COUNT_W-1:0]   o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    sse_pkg::t_state               r_state;
    sse_pkg::t_state               n_state;
    logic [sse_pkg::OP_W-1:0]      r_op;
    logic [sse_pkg::KEY_W-1:0]     r_key;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic                          r_success;
    logic                          n_success;
    logic                          r_full;
    logic                          n_full;
    logic [sse_pkg::COUNT_W-1:0]   r_out_count;
    logic [sse_pkg::COUNT_W-1:0]   n_out_count;

    sse_pkg::t_cell_ctl            cell_ctl;
    logic [sse_pkg::KEY_W-1:0]     cell_value [CAPACITY];
    logic [CAPACITY-1:0]           cell_lt;
    logic [CAPACITY-1:0]           cell_eq;
    logic                          present;
    logic                          store_at_cap;
    logic                          in_fire;
    logic                          exec_go;

    assign in_fire      = i_in_valid && o_in_ready;
    assign present      = |cell_eq;
    assign store_at_cap = (r_count == CW'(CAPACITY));
    assign exec_go      = (r_state == sse_pkg::S_EXEC) && (!r_out_valid || i_out_ready);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [sse_pkg::KEY_W-1:0] lower_value;
        logic [sse_pkg::KEY_W-1:0] upper_value;
        logic                      lower_lt;

        if (g == 0) begin : g_first
            assign lower_value = r_key;
            assign lower_lt    = 1'b1;
        end else begin : g_mid
            assign lower_value = cell_value[g-1];
            assign lower_lt    = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign upper_value = r_key;
        end else begin : g_low
            assign upper_value = cell_value[g+1];
        end

        sse_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_key         (r_key),
            .i_in_use      (r_count > CW'(g)),
            .i_lower_value (lower_value),
            .i_upper_value (upper_value),
            .i_lower_lt    (lower_lt),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g]),
            .o_eq          (cell_eq[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_success   = r_success;
        n_full      = r_full;
        n_out_count = r_out_count;
        cell_ctl    = '0;
        unique case (r_state)
            sse_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = sse_pkg::S_CMP;
                end
            end
            sse_pkg::S_CMP: begin
                cell_ctl.cmp = 1'b1;
                n_state      = sse_pkg::S_EXEC;
            end
            sse_pkg::S_EXEC: begin
                if (exec_go) begin
                    n_success = 1'b0;
                    n_full    = 1'b0;
                    priority if (r_op == sse_pkg::OP_MEMBER) begin
                        n_success = present;
                    end else if (r_op == sse_pkg::OP_INSERT && !present) begin
                        if (store_at_cap) begin
                            n_full = 1'b1;
                        end else begin
                            cell_ctl.ins = 1'b1;
                            n_count      = r_count + CW'(1);
                            n_success    = 1'b1;
                        end
                    end else if (r_op == sse_pkg::OP_DELETE && present) begin
                        cell_ctl.del = 1'b1;
                        n_count      = r_count - CW'(1);
                        n_success    = 1'b1;
                    end else begin
                        n_success = 1'b0;
                    end
                    n_out_count = sse_pkg::COUNT_W'(n_count);
                    n_out_valid = 1'b1;
                    n_state     = sse_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sse_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op  <= i_operation;
            r_key <= i_key_value;
        end
        r_success   <= n_success;
        r_full      <= n_full;
        r_out_count <= n_out_count;
    end

    assign o_in_ready    = (r_state == sse_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_success     = r_success;
    assign o_store_full  = r_full;
    assign o_entry_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("held count exceeds capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && cell_ctl.ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("successful insert did not grow the count");

    a_full_only_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && n_full) |-> (store_at_cap && r_op == sse_pkg::OP_INSERT))
        else $error("store full reported below capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("request accepted while a word is in progress");

endmodule

@@ dv/tb_sorted_set_engine_top.sv @@
module tb_sorted_set_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_CAPACITY = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1120;

    localparam logic [sse_pkg::OP_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [sse_pkg::KEY_W-1:0] KEY_MIN   = '0;
    localparam logic [sse_pkg::KEY_W-1:0] KEY_MAX   = '1;

    typedef struct packed {
        logic                        success;
        logic                        store_full;
        logic [sse_pkg::COUNT_W-1:0] entry_count;
    } t_set_result;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_MOSTLY
    } t_ready_mode;

    typedef enum int {
        MIX_BALANCED,
        MIX_FILLING,
        MIX_DRAINING
    } t_mix;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_in_valid    = 1'b0;
    logic [sse_pkg::OP_W-1:0]    i_operation   = sse_pkg::OP_MEMBER;
    logic [sse_pkg::KEY_W-1:0]   i_key_value   = '0;
    logic                        i_out_ready   = 1'b0;
    logic                        o_in_ready;
    logic                        o_out_valid;
    logic                        o_success;
    logic                        o_store_full;
    logic [sse_pkg::COUNT_W-1:0] o_entry_count;

    logic [sse_pkg::KEY_W-1:0] held_keys[$];
    t_set_result               expected_results[$];
    t_set_result               oldest_result;
    int                        error_count      = 0;
    int                        cycle_count      = 0;
    int                        burst_left       = 0;
    t_ready_mode               ready_mode       = READY_ALWAYS;
    int                        ready_phase_left = 0;
    int                        ready_tick       = 0;

    sorted_set_engine_top #(
        .CAPACITY      (SET_CAPACITY)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_key_value   (i_key_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_success     (o_success),
        .o_store_full  (o_store_full),
        .o_entry_count (o_entry_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        ready_tick <= ready_tick + 1;
        if (ready_phase_left == 0) begin
            ready_mode       <= t_ready_mode'($urandom_range(0, 3));
            ready_phase_left <= $urandom_range(8, 64);
        end else begin
            ready_phase_left <= ready_phase_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS:   i_out_ready <= 1'b1;
            READY_COIN:     i_out_ready <= ($urandom_range(0, 1) == 1);
            READY_PERIODIC: i_out_ready <= ((ready_tick % 7) < 3);
            default:        i_out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word: success %0b full %0b count %0d",
                         $time, o_success, o_store_full, o_entry_count);
                error_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (o_success !== oldest_result.success) begin
                    $display("%0t: success mismatch: expected %0b, actual %0b", $time,
                             oldest_result.success, o_success);
                    error_count++;
                end
                if (o_store_full !== oldest_result.store_full) begin
                    $display("%0t: store_full mismatch: expected %0b, actual %0b", $time,
                             oldest_result.store_full, o_store_full);
                    error_count++;
                end
                if (o_entry_count !== oldest_result.entry_count) begin
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d", $time,
                             oldest_result.entry_count, o_entry_count);
                    error_count++;
                end
            end
        end
    end

    function automatic t_set_result apply_request(logic [sse_pkg::OP_W-1:0] op,
                                                  logic [sse_pkg::KEY_W-1:0] key);
        t_set_result outcome;
        int          pos;
        bit          present;
        outcome = '0;
        pos     = 0;
        while (pos < held_keys.size() && held_keys[pos] < key) pos++;
        present = (pos < held_keys.size()) && (held_keys[pos] == key);
        case (op)
            sse_pkg::OP_MEMBER: begin
                outcome.success = present;
            end
            sse_pkg::OP_INSERT: begin
                if (!present) begin
                    if (held_keys.size() >= SET_CAPACITY) begin
                        outcome.store_full = 1'b1;
                    end else begin
                        held_keys.insert(pos, key);
                        outcome.success = 1'b1;
                    end
                end
            end
            sse_pkg::OP_DELETE: begin
                if (present) begin
                    held_keys.delete(pos);
                    outcome.success = 1'b1;
                end
            end
            default: ;
        endcase
        outcome.entry_count = sse_pkg::COUNT_W'(held_keys.size());
        return outcome;
    endfunction

    function automatic bit is_held(logic [sse_pkg::KEY_W-1:0] key);
        foreach (held_keys[i]) begin
            if (held_keys[i] == key) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [sse_pkg::KEY_W-1:0] absent_key();
        logic [sse_pkg::KEY_W-1:0] key;
        key = sse_pkg::KEY_W'($urandom);
        while (is_held(key)) key = sse_pkg::KEY_W'($urandom);
        return key;
    endfunction

    function automatic logic [sse_pkg::KEY_W-1:0] random_key(
        logic [sse_pkg::KEY_W-1:0] window_base
    );
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) == 1) ? KEY_MAX : KEY_MIN;
            1, 2, 3: return sse_pkg::KEY_W'($urandom);
            default: return window_base + sse_pkg::KEY_W'($urandom_range(0, 95));
        endcase
    endfunction

    task automatic send_word(input logic [sse_pkg::OP_W-1:0] op,
                             input logic [sse_pkg::KEY_W-1:0] key);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_key_value <= key;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(apply_request(op, key));
    endtask

    task automatic hold_until_results_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_boundary_words();
        send_word(sse_pkg::OP_MEMBER, KEY_MIN);
        send_word(sse_pkg::OP_DELETE, KEY_MAX);
        send_word(OP_UNUSED, KEY_MAX);
        send_word(sse_pkg::OP_INSERT, 16'h8000);
        send_word(sse_pkg::OP_INSERT, KEY_MIN);
        send_word(sse_pkg::OP_INSERT, KEY_MAX);
        send_word(sse_pkg::OP_INSERT, 16'h7FFF);
        send_word(sse_pkg::OP_INSERT, 16'h8001);
        send_word(sse_pkg::OP_INSERT, KEY_MIN);
        send_word(sse_pkg::OP_INSERT, KEY_MAX);
        send_word(sse_pkg::OP_MEMBER, KEY_MIN);
        send_word(sse_pkg::OP_MEMBER, KEY_MAX);
        send_word(sse_pkg::OP_MEMBER, 16'h8002);
        send_word(OP_UNUSED, 16'h8000);
        send_word(sse_pkg::OP_MEMBER, 16'h8000);
        send_word(sse_pkg::OP_DELETE, 16'h7FFF);
        send_word(sse_pkg::OP_DELETE, 16'h7FFF);
        send_word(sse_pkg::OP_DELETE, KEY_MIN);
        send_word(sse_pkg::OP_DELETE, KEY_MAX);
        send_word(sse_pkg::OP_MEMBER, KEY_MAX);
        send_word(sse_pkg::OP_DELETE, 16'h8000);
        send_word(sse_pkg::OP_DELETE, 16'h8001);
        send_word(sse_pkg::OP_INSERT, 16'h5555);
        send_word(sse_pkg::OP_MEMBER, 16'hAAAA);
        hold_until_results_drained();
    endtask

    task automatic test_fill_to_capacity();
        logic [sse_pkg::KEY_W-1:0] victim;
        while (held_keys.size() < SET_CAPACITY) send_word(sse_pkg::OP_INSERT, absent_key());
        // At capacity a new value is refused as full, but a duplicate is refused plainly.
        send_word(sse_pkg::OP_INSERT, absent_key());
        send_word(sse_pkg::OP_INSERT, KEY_MIN);
        send_word(sse_pkg::OP_INSERT, KEY_MAX);
        send_word(sse_pkg::OP_INSERT, held_keys[0]);
        send_word(sse_pkg::OP_INSERT, held_keys[SET_CAPACITY-1]);
        send_word(sse_pkg::OP_MEMBER, held_keys[SET_CAPACITY-1]);
        send_word(sse_pkg::OP_MEMBER, absent_key());
        send_word(sse_pkg::OP_DELETE, absent_key());
        send_word(OP_UNUSED, absent_key());
        victim = held_keys[SET_CAPACITY/2];
        send_word(sse_pkg::OP_DELETE, victim);
        send_word(sse_pkg::OP_INSERT, absent_key());
        send_word(sse_pkg::OP_INSERT, absent_key());
        send_word(sse_pkg::OP_INSERT, victim);
        hold_until_results_drained();
    endtask

    task automatic test_drain_to_empty();
        logic [sse_pkg::KEY_W-1:0] order[$];
        order = held_keys;
        order.shuffle();
        foreach (order[i]) begin
            send_word(sse_pkg::OP_DELETE, order[i]);
            if ($urandom_range(0, 7) == 0) send_word(sse_pkg::OP_DELETE, order[i]);
        end
        if (order.size() > 0) send_word(sse_pkg::OP_MEMBER, order[0]);
        send_word(sse_pkg::OP_DELETE, KEY_MAX);
        send_word(sse_pkg::OP_DELETE, KEY_MIN);
        hold_until_results_drained();
    endtask

    task automatic test_random_mix();
        int                        counted;
        int                        phase_left;
        int                        roll;
        t_mix                      mix;
        logic [sse_pkg::KEY_W-1:0] window_base;
        logic [sse_pkg::OP_W-1:0]  op;
        logic [sse_pkg::KEY_W-1:0] key;
        counted     = 0;
        phase_left  = 0;
        mix         = MIX_BALANCED;
        window_base = '0;
        while (counted < RANDOM_WORDS) begin
            if (phase_left == 0) begin
                if ($urandom_range(0, 2) == 0) hold_until_results_drained();
                phase_left  = $urandom_range(30, 150);
                mix         = t_mix'($urandom_range(0, 2));
                window_base = sse_pkg::KEY_W'($urandom);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op = OP_UNUSED;
            end else begin
                case (mix)
                    MIX_FILLING: begin
                        op = (roll < 70) ? sse_pkg::OP_INSERT :
                             (roll < 85) ? sse_pkg::OP_MEMBER : sse_pkg::OP_DELETE;
                    end
                    MIX_DRAINING: begin
                        op = (roll < 70) ? sse_pkg::OP_DELETE :
                             (roll < 85) ? sse_pkg::OP_MEMBER : sse_pkg::OP_INSERT;
                    end
                    default: begin
                        op = (roll < 40) ? sse_pkg::OP_INSERT :
                             (roll < 70) ? sse_pkg::OP_MEMBER : sse_pkg::OP_DELETE;
                    end
                endcase
            end
            if (held_keys.size() > 0 && $urandom_range(0, 9) < 4) begin
                key = held_keys[$urandom_range(0, held_keys.size() - 1)];
            end else begin
                key = random_key(window_base);
            end
            send_word(op, key);
            if (op != OP_UNUSED) counted++;
        end
        hold_until_results_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_boundary_words();
        test_fill_to_capacity();
        test_drain_to_empty();
        test_random_mix();
        hold_until_results_drained();
        repeat (12) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
